FILE: sv/lcdseq_pkg.sv
// shared types and constants for the character lcd bus sequencer
package lcdseq_pkg;

   localparam int unsigned TICK_W  = 16;
   localparam int unsigned RETRY_W = 10;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CSR_W   = 16;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [TICK_W-1:0]  SETUP_RESET  = 16'd200;
   localparam logic [TICK_W-1:0]  PULSE_RESET  = 16'd400;
   localparam logic [TICK_W-1:0]  HOLD_RESET   = 16'd200;
   localparam logic [RETRY_W-1:0] RETRY_RESET  = 10'd1000;

   typedef enum logic [1:0] {
      OP_TICK        = 2'd0,
      OP_WRITE_INSTR = 2'd1,
      OP_WRITE_CHAR  = 2'd2,
      OP_BUSY_POLL   = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETUP = 2'd0,
      CSR_PULSE = 2'd1,
      CSR_HOLD  = 2'd2,
      CSR_RETRY = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_WS   = 3'd1,
      PH_WP   = 3'd2,
      PH_WH   = 3'd3,
      PH_PS   = 3'd4,
      PH_PP   = 3'd5,
      PH_PH   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [BYTE_W-1:0] data_byte;
      logic [BYTE_W-1:0] bus_in;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_out;
      logic              data_drive;
      logic              rs_pin;
      logic              wr_pin;
      logic              en_pin;
      logic              ready_res;
      logic              done_res;
      logic [BYTE_W-1:0] status_byte;
      logic              timed_out;
      logic              rejected;
   } rsp_type;

   typedef struct packed {
      logic [TICK_W-1:0]  setup_ticks;
      logic [TICK_W-1:0]  pulse_ticks;
      logic [TICK_W-1:0]  hold_ticks;
      logic [RETRY_W-1:0] max_retries;
   } cfg_type;

endpackage

FILE: sv/lcdseq_core.sv
// bus phase sequencer: state update and result for one tick item
module lcdseq_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  lcdseq_pkg::req_type item,
   input  lcdseq_pkg::cfg_type cfg,
   output lcdseq_pkg::rsp_type result
);

   lcdseq_pkg::phase_type              phase_ff, phase_in;
   logic [lcdseq_pkg::TICK_W-1:0]      tick_ff, tick_in;
   logic [lcdseq_pkg::RETRY_W-1:0]     poll_ff, poll_in;
   logic [1:0]                         kind_ff, kind_in;
   logic [lcdseq_pkg::BYTE_W-1:0]      byte_ff, byte_in;
   logic                               rs_ff, rs_in;
   logic                               wr_ff, wr_in;
   logic                               en_ff, en_in;
   logic                               drive_ff, drive_in;
   logic [lcdseq_pkg::BYTE_W-1:0]      latch_ff, latch_in;
   logic [lcdseq_pkg::BYTE_W-1:0]      status_ff, status_in;
   logic                               tout_ff, tout_in;
   logic                               done, rej;
   logic [lcdseq_pkg::TICK_W-1:0]      phase_len;
   logic                               is_idle;

   always_comb begin
      case (phase_ff)
         lcdseq_pkg::PH_WS, lcdseq_pkg::PH_PS: phase_len = cfg.setup_ticks;
         lcdseq_pkg::PH_WP, lcdseq_pkg::PH_PP: phase_len = cfg.pulse_ticks;
         default:                              phase_len = cfg.hold_ticks;
      endcase
   end

   assign is_idle = !(phase_ff inside {lcdseq_pkg::PH_WS, lcdseq_pkg::PH_WP,
                                       lcdseq_pkg::PH_WH, lcdseq_pkg::PH_PS,
                                       lcdseq_pkg::PH_PP, lcdseq_pkg::PH_PH});

   // next state
   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      poll_in   = poll_ff;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      rs_in     = rs_ff;
      wr_in     = wr_ff;
      en_in     = en_ff;
      drive_in  = drive_ff;
      latch_in  = latch_ff;
      status_in = status_ff;
      tout_in   = tout_ff;
      done      = 1'b0;
      rej       = 1'b0;
      if (is_idle) begin
         phase_in = lcdseq_pkg::PH_IDLE;
         case (item.op)
            lcdseq_pkg::OP_WRITE_INSTR: begin
               kind_in  = lcdseq_pkg::OP_WRITE_INSTR;
               byte_in  = item.data_byte;
               latch_in = item.data_byte;
               drive_in = 1'b1;
               rs_in    = 1'b0;
               wr_in    = 1'b0;
               en_in    = 1'b0;
               phase_in = lcdseq_pkg::PH_WS;
               tick_in  = lcdseq_pkg::TICK_W'(1);
            end
            lcdseq_pkg::OP_WRITE_CHAR, lcdseq_pkg::OP_BUSY_POLL: begin
               kind_in  = item.op;
               if (item.op == lcdseq_pkg::OP_WRITE_CHAR) begin
                  byte_in = item.data_byte;
               end
               poll_in  = '0;
               drive_in = 1'b0;
               rs_in    = 1'b0;
               wr_in    = 1'b1;
               en_in    = 1'b0;
               phase_in = lcdseq_pkg::PH_PS;
               tick_in  = lcdseq_pkg::TICK_W'(1);
            end
            default: ;
         endcase
      end else begin
         rej = (item.op != lcdseq_pkg::OP_TICK);
         if (tick_ff < phase_len) begin
            tick_in = tick_ff + lcdseq_pkg::TICK_W'(1);
         end else begin
            tick_in = lcdseq_pkg::TICK_W'(1);
            case (phase_ff)
               lcdseq_pkg::PH_WS: begin
                  en_in    = 1'b1;
                  phase_in = lcdseq_pkg::PH_WP;
               end
               lcdseq_pkg::PH_WP: begin
                  en_in    = 1'b0;
                  phase_in = lcdseq_pkg::PH_WH;
               end
               lcdseq_pkg::PH_WH: begin
                  phase_in = lcdseq_pkg::PH_IDLE;
                  tick_in  = '0;
                  done     = 1'b1;
               end
               lcdseq_pkg::PH_PS: begin
                  en_in    = 1'b1;
                  phase_in = lcdseq_pkg::PH_PP;
               end
               lcdseq_pkg::PH_PP: begin
                  // sample the bus as enable falls
                  status_in = item.bus_in;
                  en_in     = 1'b0;
                  phase_in  = lcdseq_pkg::PH_PH;
               end
               default: begin
                  if (status_ff[7] && (poll_ff < cfg.max_retries)) begin
                     poll_in  = poll_ff + lcdseq_pkg::RETRY_W'(1);
                     drive_in = 1'b0;
                     rs_in    = 1'b0;
                     wr_in    = 1'b1;
                     en_in    = 1'b0;
                     phase_in = lcdseq_pkg::PH_PS;
                  end else begin
                     tout_in = status_ff[7];
                     if (kind_ff == lcdseq_pkg::OP_WRITE_CHAR) begin
                        latch_in = byte_ff;
                        drive_in = 1'b1;
                        rs_in    = 1'b1;
                        wr_in    = 1'b0;
                        en_in    = 1'b0;
                        phase_in = lcdseq_pkg::PH_WS;
                     end else begin
                        phase_in = lcdseq_pkg::PH_IDLE;
                        tick_in  = '0;
                        done     = 1'b1;
                     end
                  end
               end
            endcase
         end
      end
   end

   // result for this tick
   always_comb begin
      result.data_out    = latch_in;
      result.data_drive  = drive_in;
      result.rs_pin      = rs_in;
      result.wr_pin      = wr_in;
      result.en_pin      = en_in;
      result.ready_res   = (phase_in == lcdseq_pkg::PH_IDLE);
      result.done_res    = done;
      result.status_byte = status_in;
      result.timed_out   = tout_in;
      result.rejected    = rej;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= lcdseq_pkg::PH_IDLE;
         tick_ff   <= '0;
         poll_ff   <= '0;
         kind_ff   <= '0;
         byte_ff   <= '0;
         rs_ff     <= 1'b0;
         wr_ff     <= 1'b1;
         en_ff     <= 1'b0;
         drive_ff  <= 1'b0;
         latch_ff  <= '0;
         status_ff <= '0;
         tout_ff   <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         tick_ff   <= tick_in;
         poll_ff   <= poll_in;
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         rs_ff     <= rs_in;
         wr_ff     <= wr_in;
         en_ff     <= en_in;
         drive_ff  <= drive_in;
         latch_ff  <= latch_in;
         status_ff <= status_in;
         tout_ff   <= tout_in;
      end
   end

endmodule

FILE: sv/lcdseq_out_buf.sv
// two-entry result register with skid slot
module lcdseq_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  lcdseq_pkg::rsp_type push_data,
   output logic                full,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lcdseq_pkg::rsp_type rsp_data
);

   logic                head_valid_ff, head_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   lcdseq_pkg::rsp_type head_ff, head_in;
   lcdseq_pkg::rsp_type skid_ff, skid_in;
   logic                pop;

   assign pop       = head_valid_ff && !rsp_stall;
   assign full      = skid_valid_ff;
   assign rsp_valid = head_valid_ff;
   assign rsp_data  = head_ff;

   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in       = head_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in = skid_ff;
            if (push) begin
               skid_in = push_data;
            end else begin
               skid_valid_in = 1'b0;
            end
         end else if (push) begin
            head_in = push_data;
         end else begin
            head_valid_in = 1'b0;
         end
      end else if (push) begin
         // a push fills an empty head; a stalled head keeps its value and the push lands in the skid slot
         if (!head_valid_ff) begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: sv/char_lcd_bus_sequencer_top.sv
// top level of the character lcd bus sequencer
//
//   channel | ports                                | role
//   --------+--------------------------------------+----------------------------
//   request | req_valid, req_stall, req_data       | one bus tick item in
//   result  | rsp_valid, rsp_stall, rsp_data       | pin levels and status out
//   csr     | csr_wr_en, csr_index, csr_wdata      | timing and retry registers
//
// one item per clock while req_stall is low; each item passes the input register,
// then sequencer logic into the result register
// a two-entry result buffer takes a new transfer while the head waits, so
// req_stall rises only when both result slots are full
// reset is synchronous and returns the bus to idle with WR high and the
// timing registers to their defaults
module char_lcd_bus_sequencer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  lcdseq_pkg::req_type                 req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output lcdseq_pkg::rsp_type                 rsp_data,
   input  logic                                csr_wr_en,
   input  logic [lcdseq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lcdseq_pkg::CSR_W-1:0]        csr_wdata
);

   lcdseq_pkg::cfg_type cfg_ff, cfg_in;
   lcdseq_pkg::req_type in_ff, in_in;
   logic                in_valid_ff, in_valid_in;
   logic                buf_full;
   logic                accept;
   logic                advance;
   lcdseq_pkg::rsp_type result;

   assign req_stall = in_valid_ff && buf_full;
   assign accept    = req_valid && !req_stall;
   assign advance   = in_valid_ff && !buf_full;

   always_comb begin
      in_in       = accept ? req_data : in_ff;
      in_valid_in = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (lcdseq_pkg::csr_index_type'(csr_index))
            lcdseq_pkg::CSR_SETUP: cfg_in.setup_ticks = csr_wdata;
            lcdseq_pkg::CSR_PULSE: cfg_in.pulse_ticks = csr_wdata;
            lcdseq_pkg::CSR_HOLD:  cfg_in.hold_ticks  = csr_wdata;
            lcdseq_pkg::CSR_RETRY:
               cfg_in.max_retries = csr_wdata[lcdseq_pkg::RETRY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         cfg_ff.setup_ticks <= lcdseq_pkg::SETUP_RESET;
         cfg_ff.pulse_ticks <= lcdseq_pkg::PULSE_RESET;
         cfg_ff.hold_ticks  <= lcdseq_pkg::HOLD_RESET;
         cfg_ff.max_retries <= lcdseq_pkg::RETRY_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         cfg_ff      <= cfg_in;
      end
      in_ff <= in_in;
   end

   lcdseq_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   lcdseq_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (result),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a completed request always leaves the sequencer idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.ready_res)
      else $error("done without idle");

   // data lines are driven exactly when the bus is in write direction
   a_dir_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.wr_pin != rsp_data.data_drive))
      else $error("data direction disagrees with wr pin");

   // a held input item must not be lost when the result side is full
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && buf_full |=> in_valid_ff && $stable(in_ff))
      else $error("input item lost while result buffer full");

endmodule
